// ===== rtl/core/angle_bias_kalman_filter_unit_defines.svh =====
// Assertion macros shared by the checker of the angle/bias Kalman filter unit.
`ifndef ANGLE_BIAS_KALMAN_FILTER_UNIT_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ABKF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ABKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/abkf_pkg.sv =====
// Shared types, constants and saturation helpers of the angle/bias Kalman filter unit.
`default_nettype none

package abkf_pkg;

    typedef logic signed [47:0] t_cov;
    typedef logic signed [31:0] t_q16;

    localparam t_cov Max48 = 48'sh7FFF_FFFF_FFFF;
    localparam t_cov Min48 = 48'sh8000_0000_0000;
    localparam t_q16 Max32 = 32'sh7FFF_FFFF;
    localparam t_q16 Min32 = 32'sh8000_0000;

    localparam logic [31:0] ApnReset = 32'd4294967;
    localparam logic [31:0] BpnReset = 32'd12884902;
    localparam logic [31:0] MnReset  = 32'd128849019;

    // Quotient bits produced by the serial divider.
    localparam logic [5:0] DivSteps = 6'd47;
    // Partial products of the multiplier, followed by the rounding step.
    localparam logic [2:0] MulSteps = 3'd4;

    typedef enum logic [1:0] {
        CFG_APN = 2'd0,
        CFG_BPN = 2'd1,
        CFG_MN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_ANGLE,
        OP_RATE,
        OP_ANGLE_INT,
        OP_COV_T,
        OP_P00_PRED,
        OP_P11_PRED,
        OP_INNOV,
        OP_GAIN_LOAD,
        OP_GAIN_ZERO,
        OP_ANGLE_COR,
        OP_BIAS_COR,
        OP_P11_COR,
        OP_P10_COR,
        OP_P01_COR,
        OP_P00_COR
    } t_dp_op;

    typedef enum logic [3:0] {
        MS_DT_RATE,
        MS_DT_P11,
        MS_DT_T,
        MS_DT_BPN,
        MS_K0_Y,
        MS_K1_Y,
        MS_K1_P01,
        MS_K1_P00,
        MS_K0_P01,
        MS_K0_P00
    } t_msel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SET,
        S_RATE,
        S_M_ANG,
        S_M_DTP11,
        S_M_P00,
        S_M_P11,
        S_INNOV,
        S_DIV,
        S_M_ACOR,
        S_M_BCOR,
        S_M_P11C,
        S_M_P10C,
        S_M_P01C,
        S_M_P00C,
        S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   capture;
        logic   mul_start;
        t_msel  msel;
        logic   div_start;
        logic   publish;
    } t_dp_cmd;

    typedef struct packed {
        logic set_item;
        logic s_zero;
        logic mul_done;
        logic div_done;
    } t_dp_sts;

    function automatic t_cov sat48(input logic signed [49:0] v);
        if ((&v[49:47]) || !(|v[49:47])) begin
            return v[47:0];
        end else if (v[49]) begin
            return Min48;
        end else begin
            return Max48;
        end
    endfunction

    function automatic t_q16 sat32(input logic signed [49:0] v);
        if ((&v[49:31]) || !(|v[49:31])) begin
            return v[31:0];
        end else if (v[49]) begin
            return Min32;
        end else begin
            return Max32;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/abkf_mul.sv =====
// Sequential signed multiplier with rounded shift and 48-bit saturation.
`default_nettype none

module abkf_mul
    import abkf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cov i_a,
    input  wire t_cov i_b,
    input  wire logic i_sh32,
    output logic      o_done,
    output t_cov      o_res
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [47:0] r_xm;
    logic [47:0] r_ym;
    logic        r_neg;
    logic        r_sh32;
    logic [95:0] r_acc;
    t_cov        r_res;

    logic [47:0] a_mag;
    logic [47:0] b_mag;
    logic [23:0] x_dig;
    logic [23:0] y_dig;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    logic [96:0] rs;
    logic [72:0] q;
    logic        q_ge;
    t_cov        res;

    always_comb begin
        a_mag = i_a[47] ? 48'(-i_a) : 48'(i_a);
        b_mag = i_b[47] ? 48'(-i_b) : 48'(i_b);
        x_dig = r_cnt[1] ? r_xm[47:24] : r_xm[23:0];
        y_dig = r_cnt[0] ? r_ym[47:24] : r_ym[23:0];
        pp    = x_dig * y_dig;
        unique case (r_cnt[1:0])
            2'b00:   pp_sh = {48'b0, pp};
            2'b11:   pp_sh = {pp, 48'b0};
            default: pp_sh = {24'b0, pp, 24'b0};
        endcase
        // Round the magnitude half away from zero before the shift.
        rs   = 97'(r_acc) + (r_sh32 ? (97'(1) << 31) : (97'(1) << 23));
        q    = r_sh32 ? 73'(rs[96:32]) : rs[96:24];
        q_ge = |q[72:47];
        if (r_neg) begin
            res = q_ge ? Min48 : t_cov'(-q[47:0]);
        end else begin
            res = q_ge ? Max48 : t_cov'(q[47:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_xm   <= a_mag;
                r_ym   <= b_mag;
                r_neg  <= i_a[47] ^ i_b[47];
                r_sh32 <= i_sh32;
                r_acc  <= 96'd0;
            end else if (r_busy) begin
                if (r_cnt != MulSteps) begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_res  <= res;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/abkf_div_lane.sv =====
// One lane of the serial restoring divider that forms a Q16.32 gain.
`default_nettype none

module abkf_div_lane
    import abkf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cov i_num,
    input  wire t_cov i_den,
    output logic      o_done,
    output t_cov      o_res
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_ud;
    logic [48:0] r_rem;
    logic [46:0] r_shf;
    logic [46:0] r_q;
    logic        r_ovf;
    logic        r_neg;
    t_cov        r_res;

    logic [47:0] un;
    logic [47:0] ud;
    logic [48:0] rn;
    logic        take;
    logic        rnd_up;
    logic [47:0] m;
    t_cov        res;

    always_comb begin
        un     = i_num[47] ? 48'(-i_num) : 48'(i_num);
        ud     = i_den[47] ? 48'(-i_den) : 48'(i_den);
        rn     = {r_rem[47:0], r_shf[46]};
        take   = rn >= {1'b0, r_ud};
        rnd_up = {r_rem[47:0], 1'b0} >= {1'b0, r_ud};
        // An integer part of 2^15 or more sets the magnitude to 2^47, which saturates the gain.
        m      = r_ovf ? {1'b1, 47'b0} : (48'(r_q) + 48'(rnd_up));
        if (r_neg) begin
            res = t_cov'(-m);
        end else begin
            res = m[47] ? Max48 : t_cov'(m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_ud   <= ud;
                r_ovf  <= {15'b0, un} >= {ud, 15'b0};
                r_rem  <= 49'(un[47:15]);
                r_shf  <= {un[14:0], 32'b0};
                r_q    <= 47'd0;
                r_neg  <= i_num[47] ^ i_den[47];
            end else if (r_busy) begin
                if (r_cnt != DivSteps) begin
                    r_rem <= take ? (rn - {1'b0, r_ud}) : rn;
                    r_q   <= {r_q[45:0], take};
                    r_shf <= {r_shf[45:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                end else begin
                    r_res  <= res;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/abkf_dp.sv =====
// Datapath: filter state, noise registers, operand selection, multiplier and dividers.
`default_nettype none

module abkf_dp
    import abkf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_op,
    input  wire t_q16        i_meas_angle,
    input  wire t_q16        i_meas_rate,
    input  wire logic [31:0] i_time_step,
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output t_q16             o_angle,
    output t_q16             o_rate,
    output logic             o_flag
);

    logic [31:0]        r_cfg_apn;
    logic [31:0]        r_cfg_bpn;
    logic [31:0]        r_cfg_mn;
    t_q16               r_angle;
    t_q16               r_bias;
    t_q16               r_rate;
    t_cov               r_p00;
    t_cov               r_p01;
    t_cov               r_p10;
    t_cov               r_p11;
    logic               r_flag;
    logic               r_set;
    t_q16               r_meas_angle;
    t_q16               r_meas_rate;
    logic [31:0]        r_dt;
    t_cov               r_t;
    logic signed [32:0] r_y;
    t_cov               r_s;
    t_cov               r_k0;
    t_cov               r_k1;

    t_cov               mul_a;
    t_cov               mul_b;
    logic               mul_sh32;
    logic               mul_done;
    t_cov               mres;
    logic               div_done;
    logic               div1_done;
    t_cov               q0;
    t_cov               q1;
    t_cov               dt48;
    logic signed [49:0] t_sum;
    t_cov               s_sat;

    always_comb begin
        dt48     = $signed({16'b0, r_dt});
        mul_a    = dt48;
        mul_b    = 48'(r_rate);
        mul_sh32 = 1'b0;
        unique case (i_cmd.msel)
            MS_DT_RATE: mul_b = 48'(r_rate);
            MS_DT_P11:  mul_b = r_p11;
            MS_DT_T:    mul_b = r_t;
            MS_DT_BPN:  mul_b = $signed({16'b0, r_cfg_bpn});
            MS_K0_Y: begin
                mul_a = r_k0; mul_b = 48'(r_y); mul_sh32 = 1'b1;
            end
            MS_K1_Y: begin
                mul_a = r_k1; mul_b = 48'(r_y); mul_sh32 = 1'b1;
            end
            MS_K1_P01: begin
                mul_a = r_k1; mul_b = r_p01; mul_sh32 = 1'b1;
            end
            MS_K1_P00: begin
                mul_a = r_k1; mul_b = r_p00; mul_sh32 = 1'b1;
            end
            MS_K0_P01: begin
                mul_a = r_k0; mul_b = r_p01; mul_sh32 = 1'b1;
            end
            MS_K0_P00: begin
                mul_a = r_k0; mul_b = r_p00; mul_sh32 = 1'b1;
            end
            default: begin
                mul_a = dt48; mul_b = 48'(r_rate);
            end
        endcase
        t_sum = 50'(mres) - 50'(r_p01) - 50'(r_p10) + $signed({18'b0, r_cfg_apn});
        s_sat = sat48(50'(r_p00) + $signed({18'b0, r_cfg_mn}));
    end

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh32  (mul_sh32),
        .o_done  (mul_done),
        .o_res   (mres)
    );

    // Both gains share the divisor and run side by side.
    abkf_div_lane u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_p00),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_res   (q0)
    );

    abkf_div_lane u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_p10),
        .i_den   (r_s),
        .o_done  (div1_done),
        .o_res   (q1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_apn <= ApnReset;
            r_cfg_bpn <= BpnReset;
            r_cfg_mn  <= MnReset;
            r_angle   <= '0;
            r_bias    <= '0;
            r_rate    <= '0;
            r_p00     <= '0;
            r_p01     <= '0;
            r_p10     <= '0;
            r_p11     <= '0;
            r_flag    <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_idx == CFG_APN) begin
                    r_cfg_apn <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_BPN) begin
                    r_cfg_bpn <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_MN) begin
                    r_cfg_mn <= i_cfg_wdata;
                end
            end
            unique case (i_cmd.op)
                OP_SET_ANGLE: begin
                    r_angle <= r_meas_angle;
                    r_flag  <= 1'b0;
                end
                OP_RATE:      r_rate  <= sat32(50'(r_meas_rate) - 50'(r_bias));
                OP_ANGLE_INT: r_angle <= sat32(50'(r_angle) + 50'(mres));
                OP_COV_T: begin
                    r_p01 <= sat48(50'(r_p01) - 50'(mres));
                    r_p10 <= sat48(50'(r_p10) - 50'(mres));
                end
                OP_P00_PRED:  r_p00   <= sat48(50'(r_p00) + 50'(mres));
                OP_P11_PRED:  r_p11   <= sat48(50'(r_p11) + 50'(mres));
                OP_INNOV:     r_flag  <= (s_sat == '0);
                OP_ANGLE_COR: r_angle <= sat32(50'(r_angle) + 50'(mres));
                OP_BIAS_COR:  r_bias  <= sat32(50'(r_bias) + 50'(mres));
                OP_P11_COR:   r_p11   <= sat48(50'(r_p11) - 50'(mres));
                OP_P10_COR:   r_p10   <= sat48(50'(r_p10) - 50'(mres));
                OP_P01_COR:   r_p01   <= sat48(50'(r_p01) - 50'(mres));
                OP_P00_COR:   r_p00   <= sat48(50'(r_p00) - 50'(mres));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_set        <= i_op;
            r_meas_angle <= i_meas_angle;
            r_meas_rate  <= i_meas_rate;
            r_dt         <= i_time_step;
        end
        unique case (i_cmd.op)
            OP_COV_T: r_t <= sat48(t_sum);
            OP_INNOV: begin
                r_y <= 33'(r_meas_angle) - 33'(r_angle);
                r_s <= s_sat;
            end
            OP_GAIN_LOAD: begin
                r_k0 <= q0;
                r_k1 <= q1;
            end
            OP_GAIN_ZERO: begin
                r_k0 <= '0;
                r_k1 <= '0;
            end
            default: ;
        endcase
    end

    assign o_sts.set_item = r_set;
    assign o_sts.s_zero   = r_flag;
    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done & div1_done;
    assign o_angle        = r_angle;
    assign o_rate         = r_rate;
    assign o_flag         = r_flag;

endmodule

`default_nettype wire

// ===== rtl/core/abkf_ctrl.sv =====
// Controller that sequences the predict, gain and correct steps of one item.
`default_nettype none

module abkf_ctrl
    import abkf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_out_free,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_ready
);

    t_state r_state;
    t_state n_state;
    logic   r_issued;
    logic   n_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        o_cmd     = '0;
        o_cmd.op  = OP_NONE;
        o_cmd.msel = MS_DT_RATE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: n_state = i_sts.set_item ? S_SET : S_RATE;
            S_SET: begin
                o_cmd.op = OP_SET_ANGLE;
                n_state  = S_DONE;
            end
            S_RATE: begin
                o_cmd.op = OP_RATE;
                n_state  = S_M_ANG;
            end
            S_M_ANG: begin
                o_cmd.msel = MS_DT_RATE;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_ANGLE_INT; n_issued = 1'b0; n_state = S_M_DTP11;
                end
            end
            S_M_DTP11: begin
                o_cmd.msel = MS_DT_P11;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_COV_T; n_issued = 1'b0; n_state = S_M_P00;
                end
            end
            S_M_P00: begin
                o_cmd.msel = MS_DT_T;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P00_PRED; n_issued = 1'b0; n_state = S_M_P11;
                end
            end
            S_M_P11: begin
                o_cmd.msel = MS_DT_BPN;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P11_PRED; n_issued = 1'b0; n_state = S_INNOV;
                end
            end
            S_INNOV: begin
                o_cmd.op = OP_INNOV;
                n_state  = S_DIV;
            end
            S_DIV: begin
                // A zero innovation variance skips the divide; the gains are zero.
                if (i_sts.s_zero) begin
                    o_cmd.op = OP_GAIN_ZERO;
                    n_state  = S_M_ACOR;
                end else begin
                    o_cmd.div_start = !r_issued;
                    n_issued = 1'b1;
                    if (i_sts.div_done) begin
                        o_cmd.op = OP_GAIN_LOAD; n_issued = 1'b0; n_state = S_M_ACOR;
                    end
                end
            end
            S_M_ACOR: begin
                o_cmd.msel = MS_K0_Y;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_ANGLE_COR; n_issued = 1'b0; n_state = S_M_BCOR;
                end
            end
            S_M_BCOR: begin
                o_cmd.msel = MS_K1_Y;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_BIAS_COR; n_issued = 1'b0; n_state = S_M_P11C;
                end
            end
            // The covariance terms are written in an order that keeps the old
            // p00 and p01 until their last use.
            S_M_P11C: begin
                o_cmd.msel = MS_K1_P01;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P11_COR; n_issued = 1'b0; n_state = S_M_P10C;
                end
            end
            S_M_P10C: begin
                o_cmd.msel = MS_K1_P00;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P10_COR; n_issued = 1'b0; n_state = S_M_P01C;
                end
            end
            S_M_P01C: begin
                o_cmd.msel = MS_K0_P01;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P01_COR; n_issued = 1'b0; n_state = S_M_P00C;
                end
            end
            S_M_P00C: begin
                o_cmd.msel = MS_K0_P00;
                o_cmd.mul_start = !r_issued;
                n_issued = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_P00_COR; n_issued = 1'b0; n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/angle_bias_kalman_filter_unit.sv =====
// Top level of the two-state angle/bias Kalman filter unit.
// An update item makes ten passes through the shared four-step multiplier and, unless the
// innovation variance is zero, uses the 47-step serial divider that forms both gains side by side.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Synchronous active-low reset clears the filter state and restores the noise registers.
`default_nettype none

module angle_bias_kalman_filter_unit
    import abkf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // measured_angle, measured_rate, time_step
    input  wire logic        s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // angle, rate
    output logic             m_axis_tuser,  // gain_undefined
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic        ready;
    logic        start;
    logic        out_free;
    t_q16        dp_angle;
    t_q16        dp_rate;
    logic        dp_flag;
    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic        r_m_flag;

    assign start    = s_axis_tvalid & ready;
    assign out_free = !r_m_valid || m_axis_tready;

    abkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    abkf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_meas_angle (s_axis_tdata[31:0]),
        .i_meas_rate  (s_axis_tdata[63:32]),
        .i_time_step  (s_axis_tdata[95:64]),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_angle      (dp_angle),
        .o_rate       (dp_rate),
        .o_flag       (dp_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (cmd.publish) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.publish) begin
            r_m_data <= {dp_rate, dp_angle};
            r_m_flag <= dp_flag;
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_flag;

endmodule

`default_nettype wire

// ===== rtl/core/abkf_checker.sv =====
// Port-level checker of the angle/bias Kalman filter unit and its bind.
`default_nettype none

`include "angle_bias_kalman_filter_unit_defines.svh"

module abkf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    logic [1:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign out_acc = m_axis_tvalid & m_axis_tready;

    // Items accepted whose result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    `ABKF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `ABKF_ASSERT_NEXT(a_one_in_work, in_acc, !s_axis_tready, "second item taken while one is in work")
    `ABKF_ASSERT_NOW(a_no_extra_out, out_acc, r_pend != 2'd0, "result without an accepted item")
    `ABKF_ASSERT_NOW(a_ready_bound, s_axis_tready, r_pend == 2'd0 || r_pend == 2'd1, "ready with two items pending")

endmodule

bind angle_bias_kalman_filter_unit abkf_checker u_abkf_checker (.*);

`default_nettype wire
